@@ rtl/core/esat_pkg.sv @@
`default_nettype none

package esat_pkg;

  // Field widths
  localparam int ID_W     = 16;
  localparam int POS_W    = 16;
  localparam int DUR_W    = 16;
  localparam int TIME_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int MUL_W    = 18;
  localparam int PROD_W   = 2 * MUL_W;

  localparam int DEFAULT_TABLE_ENTRIES = 16;

  // Q0.16 one, needs 17 bits
  localparam logic [FRAC_W:0] ONE_Q16 = {1'b1, {FRAC_W{1'b0}}};

  // Position reported for an unknown tile
  localparam logic [POS_W-1:0] NOT_FOUND_POS = {POS_W{1'b1}};

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_QUERY = 2'd1,
    OP_TICK  = 2'd2
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INSERT,
    ST_EVAL,
    ST_DIV,
    ST_MUL_SQ,
    ST_MUL_CUBE,
    ST_MUL_DELTA,
    ST_SUM
  } state_t;

  // One stored slide
  typedef struct packed {
    logic        [ID_W-1:0]   id;
    logic signed [POS_W-1:0]  start_x;
    logic signed [POS_W-1:0]  target_x;
    logic        [TIME_W-1:0] begin_time;
    logic        [DUR_W-1:0]  duration;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/core/esat_ram.sv @@
`default_nettype none

module esat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/eased_slide_animation_table_core.sv @@
// Tick: busy stays low. Start: busy through the id scan and the insert.
// Query: busy until the strobe, which follows the id scan for an unknown id, the scan and
// the evaluation for a finished slide, and also the divider and multiplier for an eased one.
// The id scan walks the entry RAM one entry per cycle; an eased query then runs a bit-serial
// divider (16 steps) and one shared 18x18 multiplier (3 passes). One request at a time.
// Synchronous active-low reset empties the table, zeroes the time counter and victim pointer.
`default_nettype none

module eased_slide_animation_table_core
  import esat_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              in_opcode,
  input  wire logic [ID_W-1:0]         in_tile_id,
  input  wire logic signed [POS_W-1:0] in_from_x,
  input  wire logic signed [POS_W-1:0] in_to_x,
  input  wire logic [DUR_W-1:0]        in_duration_ms,
  output logic                         out_valid,
  output logic signed [POS_W-1:0]      out_position,
  output logic                         out_found
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);
  localparam logic [3:0]       DIV_LAST = 4'(FRAC_W - 1);

  state_t state_r, state_nxt;

  // Latched request
  opcode_t                  req_op_r;
  logic [ID_W-1:0]          req_id_r;
  logic signed [POS_W-1:0]  req_from_r;
  logic signed [POS_W-1:0]  req_to_r;
  logic [DUR_W-1:0]         req_dur_r;

  // Table state
  logic [TIME_W-1:0]        time_r;
  logic [IDX_W-1:0]         victim_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [TABLE_ENTRIES-1:0] done_r;

  // Scan state
  logic [CNT_W-1:0]         cnt_r;
  logic                     hit_r;
  logic [IDX_W-1:0]         hit_idx_r;
  entry_t                   hit_entry_r;
  logic                     free_r;
  logic [IDX_W-1:0]         free_idx_r;

  // Arithmetic state
  logic [DUR_W-1:0]         rem_r;
  logic [FRAC_W-1:0]        quot_r;
  logic [3:0]               div_cnt_r;
  logic [FRAC_W:0]          q_r;
  logic signed [PROD_W-1:0] prod_r;

  // Result registers
  logic                     out_valid_r;
  logic signed [POS_W-1:0]  out_position_r;
  logic                     out_found_r;

  logic                     accept;
  logic [CNT_W-1:0]         ev_cnt;
  logic [IDX_W-1:0]         ev_idx;
  logic                     ev_live;
  logic                     ev_match;
  logic                     ev_free;
  logic                     scan_end;
  logic                     hit_any;
  entry_t                   rd_entry;
  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;
  logic                     wr_en;
  logic [IDX_W-1:0]         slot;
  logic                     use_victim;
  entry_t                   wr_entry;
  logic [TIME_W-1:0]        elapsed;
  logic                     expired;
  logic                     finished;
  logic [DUR_W:0]           rem_sh;
  logic [DUR_W:0]           dur_ext;
  logic                     div_ge;
  logic [DUR_W:0]           rem_sub;
  logic [FRAC_W:0]          q_now;
  logic [FRAC_W:0]          ease;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W-1:0] total;
  logic signed [PROD_W-1:0] total_sh;
  logic signed [PROD_W-1:0] total_tz;
  logic signed [POS_W:0]    delta;
  logic                     res_fire;
  logic [POS_W-1:0]         res_pos;
  logic                     res_found;

  assign accept = start && !busy;

  // Scan bookkeeping: data for entry cnt_r - 1 arrives this cycle
  assign ev_cnt   = cnt_r - CNT_W'(1);
  assign ev_idx   = ev_cnt[IDX_W-1:0];
  assign ev_live  = (state_r == ST_SCAN) && (cnt_r != '0);
  assign ev_match = ev_live && valid_r[ev_idx] && (rd_entry.id == req_id_r);
  assign ev_free  = ev_live && !valid_r[ev_idx];
  assign scan_end = (state_r == ST_SCAN) && (cnt_r == CNT_END);
  assign hit_any  = hit_r || ev_match;
  assign rd_addr  = (cnt_r < CNT_END) ? cnt_r[IDX_W-1:0] : '0;

  // Pick the slot for a start request
  assign use_victim = !hit_r && !free_r;
  assign slot       = hit_r ? hit_idx_r : (free_r ? free_idx_r : victim_r);

  always_comb begin
    wr_entry            = '0;
    wr_entry.id         = req_id_r;
    wr_entry.start_x    = req_from_r;
    wr_entry.target_x   = req_to_r;
    wr_entry.begin_time = time_r;
    wr_entry.duration   = req_dur_r;
  end

  esat_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  // Elapsed time and finish test
  assign elapsed  = time_r - hit_entry_r.begin_time;
  assign expired  = elapsed >= {{(TIME_W-DUR_W){1'b0}}, hit_entry_r.duration};
  assign finished = done_r[hit_idx_r] || expired;

  // Restoring divider step: p = (elapsed << 16) / duration
  assign rem_sh  = {rem_r, 1'b0};
  assign dur_ext = {1'b0, hit_entry_r.duration};
  assign div_ge  = rem_sh >= dur_ext;
  assign rem_sub = div_ge ? (rem_sh - dur_ext) : rem_sh;

  assign q_now = ONE_Q16 - {1'b0, quot_r};
  assign ease  = ONE_Q16 - prod_r[2*FRAC_W:FRAC_W];
  assign delta = {hit_entry_r.target_x[POS_W-1], hit_entry_r.target_x}
               - {hit_entry_r.start_x[POS_W-1], hit_entry_r.start_x};

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL_SQ: begin
        mul_a = signed'({1'b0, q_now});
        mul_b = signed'({1'b0, q_now});
      end
      ST_MUL_CUBE: begin
        mul_a = signed'({1'b0, prod_r[2*FRAC_W:FRAC_W]});
        mul_b = signed'({1'b0, q_r});
      end
      ST_MUL_DELTA: begin
        mul_a = MUL_W'(delta);
        mul_b = signed'({1'b0, ease});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Final sum, truncated toward zero
  assign total    = {{(PROD_W-POS_W-FRAC_W){hit_entry_r.start_x[POS_W-1]}},
                     hit_entry_r.start_x, {FRAC_W{1'b0}}} + prod_r;
  assign total_sh = total >>> FRAC_W;
  assign total_tz = (total[PROD_W-1] && (total[FRAC_W-1:0] != '0))
                  ? (total_sh + PROD_W'(1)) : total_sh;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (opcode_t'(in_opcode))
            OP_START, OP_QUERY: state_nxt = ST_SCAN;
            default:            state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          if (req_op_r == OP_START) begin
            state_nxt = ST_INSERT;
          end else if (hit_any) begin
            state_nxt = ST_EVAL;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_INSERT:    state_nxt = ST_IDLE;
      ST_EVAL:      state_nxt = finished ? ST_IDLE : ST_DIV;
      ST_DIV:       state_nxt = (div_cnt_r == DIV_LAST) ? ST_MUL_SQ : ST_DIV;
      ST_MUL_SQ:    state_nxt = ST_MUL_CUBE;
      ST_MUL_CUBE:  state_nxt = ST_MUL_DELTA;
      ST_MUL_DELTA: state_nxt = ST_SUM;
      ST_SUM:       state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs and result select
  always_comb begin
    busy      = (state_r != ST_IDLE);
    rd_en     = (state_r == ST_SCAN);
    wr_en     = (state_r == ST_INSERT);
    res_fire  = 1'b0;
    res_pos   = NOT_FOUND_POS;
    res_found = 1'b0;
    case (state_r)
      ST_SCAN: begin
        if (scan_end && (req_op_r == OP_QUERY) && !hit_any) begin
          res_fire = 1'b1;
        end
      end
      ST_EVAL: begin
        if (finished) begin
          res_fire  = 1'b1;
          res_pos   = hit_entry_r.target_x;
          res_found = 1'b1;
        end
      end
      ST_SUM: begin
        res_fire  = 1'b1;
        res_pos   = total_tz[POS_W-1:0];
        res_found = 1'b1;
      end
      default: begin
        res_fire = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      time_r      <= '0;
      victim_r    <= '0;
      valid_r     <= '0;
      done_r      <= '0;
      cnt_r       <= '0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= res_fire;

      // Advance the millisecond counter
      if (accept && (opcode_t'(in_opcode) == OP_TICK)) begin
        time_r <= time_r + TIME_W'(1);
      end

      // Clear the scan on a new request, then walk the table
      if (accept) begin
        cnt_r  <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        if (!scan_end) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        if (ev_match && !hit_r) begin
          hit_r <= 1'b1;
        end
        if (ev_free && !free_r) begin
          free_r <= 1'b1;
        end
      end

      // Store the slide
      if (state_r == ST_INSERT) begin
        valid_r[slot] <= 1'b1;
        done_r[slot]  <= 1'b0;
        if (use_victim) begin
          victim_r <= (victim_r == LAST_IDX) ? '0 : (victim_r + IDX_W'(1));
        end
      end

      // Mark the entry finished
      if ((state_r == ST_EVAL) && expired) begin
        done_r[hit_idx_r] <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op_r   <= opcode_t'(in_opcode);
      req_id_r   <= in_tile_id;
      req_from_r <= in_from_x;
      req_to_r   <= in_to_x;
      req_dur_r  <= in_duration_ms;
    end

    // Capture the lowest matching entry and the lowest free slot
    if (ev_match && !hit_r) begin
      hit_idx_r   <= ev_idx;
      hit_entry_r <= rd_entry;
    end
    if (ev_free && !free_r) begin
      free_idx_r <= ev_idx;
    end

    // Divider
    if (state_r == ST_EVAL) begin
      rem_r     <= elapsed[DUR_W-1:0];
      quot_r    <= '0;
      div_cnt_r <= '0;
    end else if (state_r == ST_DIV) begin
      rem_r     <= rem_sub[DUR_W-1:0];
      quot_r    <= {quot_r[FRAC_W-2:0], div_ge};
      div_cnt_r <= div_cnt_r + 4'd1;
    end

    // Multiplier passes
    if (state_r == ST_MUL_SQ) begin
      q_r <= q_now;
    end
    if ((state_r == ST_MUL_SQ) || (state_r == ST_MUL_CUBE) || (state_r == ST_MUL_DELTA)) begin
      prod_r <= mul_p;
    end

    if (res_fire) begin
      out_position_r <= res_pos;
      out_found_r    <= res_found;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_position = out_position_r;
  assign out_found    = out_found_r;

  // Result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // Results show only once the block is free again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // Unknown id reports minus one
  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_position == NOT_FOUND_POS))
    else $error("miss result carries a position");

  // A tick never occupies the block
  a_tick_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_opcode == OP_TICK)) |=> !busy)
    else $error("tick left the block busy");

  // Divider remainder stays below the duration
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < hit_entry_r.duration))
    else $error("divider remainder out of range");

endmodule

`default_nettype wire
